/* rtl/core/pngf_pkg.sv */
// pngf_pkg: shared types, codes and constants of the png forward row filter
// no dependencies; used by every module under rtl/core

package pngf_pkg;

    // default history depth in bytes (widest pixel)
    localparam int MAX_BPP_DEFAULT = 8;

    // field widths
    localparam int BYTE_W   = 8;
    localparam int FTYPE_W  = 3;
    localparam int BPP_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TYPE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PREV_PRESENT = 2'd2;

    // filter codes (codes above paeth act as none)
    localparam logic [FTYPE_W-1:0] FT_NONE  = 3'd0;
    localparam logic [FTYPE_W-1:0] FT_SUB   = 3'd1;
    localparam logic [FTYPE_W-1:0] FT_UP    = 3'd2;
    localparam logic [FTYPE_W-1:0] FT_AVG   = 3'd3;
    localparam logic [FTYPE_W-1:0] FT_PAETH = 3'd4;

    // queue depth between front and back
    localparam int QUEUE_DEPTH = 2;

    // one classified byte handed from front to back
    typedef struct packed {
        logic [FTYPE_W-1:0] mode;     // effective filter, already reduced
        logic [BYTE_W-1:0]  raw;
        logic [BYTE_W-1:0]  a;        // left
        logic [BYTE_W-1:0]  b;        // above
        logic [BYTE_W-1:0]  c;        // up-left
        logic               row_end;
    } t_item;

endpackage

/* rtl/core/pngf_front.sv */
// pngf_front: input side; config registers, neighbor histories, row position
// depends on pngf_pkg; feeds pngf_queue

module pngf_front #(
    parameter int MAX_BYTES_PER_PIXEL = pngf_pkg::MAX_BPP_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pngf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [pngf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_valid,
    input  logic [pngf_pkg::BYTE_W-1:0]       i_raw,
    input  logic [pngf_pkg::BYTE_W-1:0]       i_above,
    input  logic                              i_row_end,
    input  logic                              i_q_full,
    output logic                              o_ready,
    output logic                              o_push,
    output pngf_pkg::t_item                   o_item
);

    localparam int PW = $clog2(MAX_BYTES_PER_PIXEL + 1);
    localparam int IW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

    logic [pngf_pkg::FTYPE_W-1:0] r_ftype;
    logic [pngf_pkg::BPP_W-1:0]   r_bpp;
    logic                         r_prev;
    logic [PW-1:0]                r_pos;
    logic [pngf_pkg::BYTE_W-1:0]  r_left   [MAX_BYTES_PER_PIXEL];
    logic [pngf_pkg::BYTE_W-1:0]  r_upleft [MAX_BYTES_PER_PIXEL];

    logic [4:0]                   bpp_eff;
    logic [IW-1:0]                idx;
    logic                         have_left;
    logic [pngf_pkg::BYTE_W-1:0]  above_eff;
    logic [pngf_pkg::FTYPE_W-1:0] mode;
    logic                         accept;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign o_push  = accept;

    // zero bpp counts as one, oversize clamps to the history depth
    always_comb begin
        if (r_bpp == '0) begin
            bpp_eff = 5'd1;
        end else if (32'({1'b0, r_bpp}) > 32'(MAX_BYTES_PER_PIXEL)) begin
            bpp_eff = 5'(MAX_BYTES_PER_PIXEL);
        end else begin
            bpp_eff = {1'b0, r_bpp};
        end
    end

    assign idx       = IW'(bpp_eff - 5'd1);
    assign have_left = 32'(r_pos) >= 32'(bpp_eff);
    assign above_eff = r_prev ? i_above : '0;

    // reduce mode: no previous row turns up into none and paeth into sub
    always_comb begin
        unique case (r_ftype)
            pngf_pkg::FT_SUB:   mode = pngf_pkg::FT_SUB;
            pngf_pkg::FT_UP:    mode = r_prev ? pngf_pkg::FT_UP : pngf_pkg::FT_NONE;
            pngf_pkg::FT_AVG:   mode = pngf_pkg::FT_AVG;
            pngf_pkg::FT_PAETH: mode = r_prev ? pngf_pkg::FT_PAETH : pngf_pkg::FT_SUB;
            default:            mode = pngf_pkg::FT_NONE;
        endcase
    end

    always_comb begin
        o_item.mode    = mode;
        o_item.raw     = i_raw;
        o_item.a       = have_left ? r_left[idx] : '0;
        o_item.b       = above_eff;
        o_item.c       = (have_left && r_prev) ? r_upleft[idx] : '0;
        o_item.row_end = i_row_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ftype <= pngf_pkg::FT_NONE;
            r_bpp   <= pngf_pkg::BPP_W'(1);
            r_prev  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pngf_pkg::CFG_FILTER_TYPE:  r_ftype <= i_cfg_data[pngf_pkg::FTYPE_W-1:0];
                pngf_pkg::CFG_BPP:          r_bpp   <= i_cfg_data[pngf_pkg::BPP_W-1:0];
                pngf_pkg::CFG_PREV_PRESENT: r_prev  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // position within the row, saturating at the history depth
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
        end else if (accept) begin
            if (i_row_end) begin
                r_pos <= '0;
            end else if (r_pos < PW'(MAX_BYTES_PER_PIXEL)) begin
                r_pos <= r_pos + PW'(1);
            end
        end
    end

    // history shift lines; hidden by the position gate until filled
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_left[0]   <= i_raw;
            r_upleft[0] <= above_eff;
            for (int k = 1; k < MAX_BYTES_PER_PIXEL; k++) begin
                r_left[k]   <= r_left[k-1];
                r_upleft[k] <= r_upleft[k-1];
            end
        end
    end

endmodule

/* rtl/core/pngf_queue.sv */
// pngf_queue: short fifo of classified bytes between front and back
// depends on pngf_pkg (t_item, QUEUE_DEPTH)

module pngf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pngf_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output pngf_pkg::t_item o_item
);

    localparam int AW = $clog2(pngf_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(pngf_pkg::QUEUE_DEPTH + 1);

    pngf_pkg::t_item r_mem [pngf_pkg::QUEUE_DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;

    assign o_full  = r_count == CW'(pngf_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* rtl/core/pngf_back.sv */
// pngf_back: predictor (sub, up, average, paeth) and output register
// depends on pngf_pkg; pops pngf_queue

module pngf_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  pngf_pkg::t_item             i_item,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pngf_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_row_end
);

    logic                        r_valid;
    logic [pngf_pkg::BYTE_W-1:0] r_byte;
    logic                        r_row_end;

    logic [pngf_pkg::BYTE_W-1:0] lo;
    logic [pngf_pkg::BYTE_W-1:0] hi;
    logic signed [10:0]          t;
    logic [8:0]                  sum_ab;
    logic [pngf_pkg::BYTE_W-1:0] paeth;
    logic [pngf_pkg::BYTE_W-1:0] pred;

    assign o_pop     = i_q_valid && (!r_valid || i_ready);
    assign o_valid   = r_valid;
    assign o_byte    = r_byte;
    assign o_row_end = r_row_end;

    assign lo     = (i_item.a < i_item.b) ? i_item.a : i_item.b;
    assign hi     = (i_item.a < i_item.b) ? i_item.b : i_item.a;
    // threshold form: t = 3c - a - b
    assign t      = $signed({3'b000, i_item.c}) + $signed({2'b00, i_item.c, 1'b0})
                  - $signed({3'b000, i_item.a}) - $signed({3'b000, i_item.b});
    assign sum_ab = {1'b0, i_item.a} + {1'b0, i_item.b};

    always_comb begin
        if (t >= $signed({3'b000, hi})) begin
            paeth = lo;
        end else if (t <= $signed({3'b000, lo})) begin
            paeth = hi;
        end else begin
            paeth = i_item.c;
        end
    end

    always_comb begin
        unique case (i_item.mode)
            pngf_pkg::FT_SUB:   pred = i_item.a;
            pngf_pkg::FT_UP:    pred = i_item.b;
            pngf_pkg::FT_AVG:   pred = sum_ab[8:1];
            pngf_pkg::FT_PAETH: pred = paeth;
            default:            pred = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_byte    <= i_item.raw - pred;
            r_row_end <= i_item.row_end;
        end
    end

endmodule

/* rtl/core/png_forward_row_filter.sv */
// png_forward_row_filter: top level of the forward png scanline filter
// depends on pngf_pkg, pngf_front, pngf_queue, pngf_back
//
//  channel  | direction | payload                              | handshake
//  ---------+-----------+--------------------------------------+------------------
//  s_axis   | in        | tdata: raw[7:0], above[15:8]; tlast  | tvalid / tready
//  m_axis   | out       | tdata: filtered[7:0]; tlast          | tvalid / tready
//  cfg      | in        | index 0 type, 1 bpp, 2 prev present  | i_cfg_we, no wait
//
// one beat per clock sustained while m_axis_tready stays high; a taken byte passes
// through a queue slot and then the output register before it shows on m_axis
// synchronous active-low reset resets config, clears row position, queue and output valid
// s_axis_tready falls only when the two-entry queue is full, i.e. after m_axis stalls
// long enough to back up the output register and the queue

module png_forward_row_filter #(
    parameter int MAX_BYTES_PER_PIXEL = pngf_pkg::MAX_BPP_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [pngf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pngf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,   // raw_byte[7:0], above_byte[15:8]
    input  logic                            s_axis_tlast,   // row_end
    // output stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [7:0]                      m_axis_tdata,   // filtered_byte[7:0]
    output logic                            m_axis_tlast    // row_end_out
);

    logic            q_full;
    logic            q_push;
    logic            q_pop;
    logic            q_valid;
    pngf_pkg::t_item push_item;
    pngf_pkg::t_item head_item;

    // front: classify each beat, pick left / above / up-left neighbors
    pngf_front #(
        .MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (s_axis_tvalid),
        .i_raw       (s_axis_tdata[7:0]),
        .i_above     (s_axis_tdata[15:8]),
        .i_row_end   (s_axis_tlast),
        .i_q_full    (q_full),
        .o_ready     (s_axis_tready),
        .o_push      (q_push),
        .o_item      (push_item)
    );

    // decoupling queue
    pngf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (push_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (head_item)
    );

    // back: predictor and subtract, registered toward m_axis
    pngf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_item    (head_item),
        .o_pop     (q_pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_row_end (m_axis_tlast)
    );

endmodule
